// ----- rtl/hltd_pkg.sv -----
// ----------------------------------------------------------------------------
// hltd_pkg
// Shared types and constants of the header / length / tail deframer.
// ----------------------------------------------------------------------------
package hltd_pkg;

  localparam int LEN_BYTES         = 2;
  localparam int MAX_FRAME_PAYLOAD = 4096;

  localparam int LEN_W    = 8 * LEN_BYTES;
  localparam int IDX_W    = $clog2(LEN_BYTES);
  localparam int CNT_W    = $clog2(MAX_FRAME_PAYLOAD + 1);
  localparam int MAXLEN_W = 13;
  localparam int CMP_W0   = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int CMP_W    = (CMP_W0 > MAXLEN_W) ? CMP_W0 : MAXLEN_W;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [MAXLEN_W-1:0] MAX_LEN_RESET = MAXLEN_W'(4096);

  localparam logic [2:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [2:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [2:0] REG_TAIL_FIRST    = 3'd2;
  localparam logic [2:0] REG_TAIL_SECOND   = 3'd3;
  localparam logic [2:0] REG_MAX_LEN       = 3'd4;

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_LEN,
    PH_BODY,
    PH_TAIL1,
    PH_TAIL2
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_DROP    = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_HEADER = 2'd1,
    CAUSE_LENGTH = 2'd2
  } cause_e;

  typedef struct packed {
    logic [7:0]          header_first;
    logic [7:0]          header_second;
    logic [7:0]          tail_first;
    logic [7:0]          tail_second;
    logic [MAXLEN_W-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    cause_e     error_cause;
    kind_e      out_kind;
    logic [7:0] out_byte;
  } result_t;

endpackage

// ----- rtl/header_length_tail_deframer.sv -----
// ----------------------------------------------------------------------------
// header_length_tail_deframer
// Deframes a byte stream of header, signed length, payload and tail.
// ----------------------------------------------------------------------------
// One received byte is taken per clock. The frame phase logic decides on each
// byte in the cycle it is accepted and its result (payload byte, accept or
// drop marker, session error) is registered before it shows on the master
// side. A result register plus one skid entry sit on the output, so
// s_axis_tready only falls when the output has stalled with two results held;
// with the output always ready the rate is one byte per cycle. A header
// mismatch or an invalid length reports one error and the block then ignores
// all input until reset. No memories, no clearing pass after reset.
module header_length_tail_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,   // [7:0] rx_byte
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [7:0]                  m_axis_tdata_o,   // [7:0] out_byte
  output logic [3:0]                  m_axis_tuser_o,   // [1:0] out_kind, [3:2] error_cause
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hltd_pkg::ADDR_W-1:0] paddr,
  input  logic [hltd_pkg::DATA_W-1:0] pwdata,
  output logic [hltd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  hltd_pkg::cfg_t    cfg;
  hltd_pkg::result_t res;
  hltd_pkg::result_t out_res;
  logic              res_valid;
  logic              accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  hltd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  hltd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (s_axis_tdata_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hltd_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_res_i    (res),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata_o = out_res.out_byte;
  assign m_axis_tuser_o = {out_res.error_cause, out_res.out_kind};

endmodule

// ----- rtl/hltd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hltd_cfg_regs
// APB register file holding the expected header and tail bytes and the
// payload length limit.
// ----------------------------------------------------------------------------
module hltd_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [hltd_pkg::ADDR_W-1:0] paddr_i,
  input  logic [hltd_pkg::DATA_W-1:0] pwdata_i,
  output logic [hltd_pkg::DATA_W-1:0] prdata_o,
  output logic                        pready_o,
  output hltd_pkg::cfg_t              cfg_o
);

  hltd_pkg::cfg_t cfg_q;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx  = paddr_i[4:2];
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= '0;
      cfg_q.header_second <= '0;
      cfg_q.tail_first    <= '0;
      cfg_q.tail_second   <= '0;
      cfg_q.max_len       <= hltd_pkg::MAX_LEN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        hltd_pkg::REG_HEADER_FIRST:  cfg_q.header_first  <= pwdata_i[7:0];
        hltd_pkg::REG_HEADER_SECOND: cfg_q.header_second <= pwdata_i[7:0];
        hltd_pkg::REG_TAIL_FIRST:    cfg_q.tail_first    <= pwdata_i[7:0];
        hltd_pkg::REG_TAIL_SECOND:   cfg_q.tail_second   <= pwdata_i[7:0];
        hltd_pkg::REG_MAX_LEN: begin
          cfg_q.max_len <= pwdata_i[hltd_pkg::MAXLEN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hltd_pkg::REG_HEADER_FIRST:  prdata_o = hltd_pkg::DATA_W'(cfg_q.header_first);
      hltd_pkg::REG_HEADER_SECOND: prdata_o = hltd_pkg::DATA_W'(cfg_q.header_second);
      hltd_pkg::REG_TAIL_FIRST:    prdata_o = hltd_pkg::DATA_W'(cfg_q.tail_first);
      hltd_pkg::REG_TAIL_SECOND:   prdata_o = hltd_pkg::DATA_W'(cfg_q.tail_second);
      hltd_pkg::REG_MAX_LEN:       prdata_o = hltd_pkg::DATA_W'(cfg_q.max_len);
      default:                     prdata_o = '0;
    endcase
  end

endmodule

// ----- rtl/hltd_parser.sv -----
// ----------------------------------------------------------------------------
// hltd_parser
// Frame phase tracker: checks header, gathers and checks the length, counts
// payload bytes and checks the tail, one byte per accepted request.
// ----------------------------------------------------------------------------
module hltd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  hltd_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  output hltd_pkg::result_t res_o
);

  hltd_pkg::phase_e               phase_q, phase_d;
  logic [7:0]                     held_q, held_d;
  logic [hltd_pkg::LEN_W-1:0]     len_q, len_d;
  logic [hltd_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic [hltd_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic                           dead_q, dead_d;

  logic [hltd_pkg::LEN_W-1:0]     len_word;
  logic [hltd_pkg::CMP_W-1:0]     len_ext;
  logic                           len_last;
  logic                           len_bad;
  logic                           hdr_bad;
  logic                           tail_ok;
  logic                           step;

  assign step = accept_i && !dead_q;

  always_comb begin
    len_word               = len_q;
    len_word[idx_q*8 +: 8] = rx_byte_i;
  end

  assign len_ext  = hltd_pkg::CMP_W'(len_word);
  assign len_last = (idx_q == hltd_pkg::IDX_W'(hltd_pkg::LEN_BYTES - 1));
  assign len_bad  = len_word[hltd_pkg::LEN_W-1] || (len_word == '0) ||
                    (len_ext > hltd_pkg::CMP_W'(cfg_i.max_len)) ||
                    (len_ext > hltd_pkg::CMP_W'(hltd_pkg::MAX_FRAME_PAYLOAD));
  assign hdr_bad  = (held_q != cfg_i.header_first) || (rx_byte_i != cfg_i.header_second);
  assign tail_ok  = (held_q == cfg_i.tail_first) && (rx_byte_i == cfg_i.tail_second);

  // next state
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    len_d   = len_q;
    idx_d   = idx_q;
    rem_d   = rem_q;
    dead_d  = dead_q;
    if (step) begin
      case (phase_q)
        hltd_pkg::PH_HEAD1: begin
          held_d  = rx_byte_i;
          phase_d = hltd_pkg::PH_HEAD2;
        end
        hltd_pkg::PH_HEAD2: begin
          if (hdr_bad) begin
            dead_d  = 1'b1;
            phase_d = hltd_pkg::PH_HEAD1;
          end else begin
            len_d   = '0;
            idx_d   = '0;
            phase_d = hltd_pkg::PH_LEN;
          end
        end
        hltd_pkg::PH_LEN: begin
          len_d = len_word;
          idx_d = idx_q + 1'b1;
          if (len_last) begin
            if (len_bad) begin
              dead_d  = 1'b1;
              phase_d = hltd_pkg::PH_HEAD1;
            end else begin
              rem_d   = len_ext[hltd_pkg::CNT_W-1:0];
              phase_d = hltd_pkg::PH_BODY;
            end
          end
        end
        hltd_pkg::PH_BODY: begin
          if (rem_q != '0) begin
            rem_d = rem_q - 1'b1;
          end
          if (rem_q <= hltd_pkg::CNT_W'(1)) begin
            phase_d = hltd_pkg::PH_TAIL1;
          end
        end
        hltd_pkg::PH_TAIL1: begin
          held_d  = rx_byte_i;
          phase_d = hltd_pkg::PH_TAIL2;
        end
        hltd_pkg::PH_TAIL2: begin
          phase_d = hltd_pkg::PH_HEAD1;
        end
        default: begin
          phase_d = hltd_pkg::PH_HEAD1;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid_o       = 1'b0;
    res_o.out_byte    = '0;
    res_o.out_kind    = hltd_pkg::KIND_PAYLOAD;
    res_o.error_cause = hltd_pkg::CAUSE_NONE;
    case (phase_q)
      hltd_pkg::PH_HEAD2: begin
        if (hdr_bad) begin
          res_valid_o       = step;
          res_o.out_kind    = hltd_pkg::KIND_ERROR;
          res_o.error_cause = hltd_pkg::CAUSE_HEADER;
        end
      end
      hltd_pkg::PH_LEN: begin
        if (len_last && len_bad) begin
          res_valid_o       = step;
          res_o.out_kind    = hltd_pkg::KIND_ERROR;
          res_o.error_cause = hltd_pkg::CAUSE_LENGTH;
        end
      end
      hltd_pkg::PH_BODY: begin
        res_valid_o    = step;
        res_o.out_byte = rx_byte_i;
      end
      hltd_pkg::PH_TAIL2: begin
        res_valid_o    = step;
        res_o.out_kind = tail_ok ? hltd_pkg::KIND_ACCEPT : hltd_pkg::KIND_DROP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hltd_pkg::PH_HEAD1;
      held_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      rem_q   <= '0;
      dead_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      rem_q   <= rem_d;
      dead_q  <= dead_d;
    end
  end

endmodule

// ----- rtl/hltd_out_buf.sv -----
// ----------------------------------------------------------------------------
// hltd_out_buf
// Result register with a skid stage so the input side can hand over one more
// result while the output side stalls.
// ----------------------------------------------------------------------------
module hltd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  hltd_pkg::result_t in_res_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hltd_pkg::result_t out_res_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  hltd_pkg::result_t out_q;
  hltd_pkg::result_t skid_q;
  logic              pop;

  assign pop         = out_valid_q && out_ready_i;
  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_valid_i) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (in_valid_i) begin
      if (!out_valid_q || pop) begin
        out_q <= in_res_i;
      end else begin
        skid_q <= in_res_i;
      end
    end
  end

endmodule

// ----- rtl/hltd_checker.sv -----
// ----------------------------------------------------------------------------
// hltd_checker
// Port-level checks of the deframer output stream.
// ----------------------------------------------------------------------------
module hltd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [3:0] m_axis_tuser_o
);

  logic is_err;
  logic is_payload;

  assign is_err     = (m_axis_tuser_o[1:0] == hltd_pkg::KIND_ERROR);
  assign is_payload = (m_axis_tuser_o[1:0] == hltd_pkg::KIND_PAYLOAD);

  // stalled request holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output request changed while stalled");

  a_cause_only_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !is_err |-> m_axis_tuser_o[3:2] == hltd_pkg::CAUSE_NONE)
    else $error("error cause without error kind");

  a_err_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && is_err |->
      (m_axis_tuser_o[3:2] == hltd_pkg::CAUSE_HEADER ||
       m_axis_tuser_o[3:2] == hltd_pkg::CAUSE_LENGTH))
    else $error("error without a cause");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !is_payload |-> m_axis_tdata_o == 8'd0)
    else $error("marker carries data");

  // session is dead after an error
  a_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && is_err |=> !m_axis_tvalid_o)
    else $error("output after session error");

endmodule

bind header_length_tail_deframer hltd_checker u_hltd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ----- tb/sv/header_length_tail_deframer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_length_tail_deframer_tb
// Self-checking bench for the header / length / tail deframer.
// ----------------------------------------------------------------------------
// Byte requests are fed in random bursts and the predicted payload, accept,
// drop and error results are kept in order and compared field by field with
// what leaves the master side, which stalls on its own pattern. The run steps
// through several register settings between frames, ends on one randomly
// chosen fatal header or length fault and checks that the dead session then
// stays silent.
// ----------------------------------------------------------------------------
module header_length_tail_deframer_tb;

  localparam int CYCLE_LIMIT = 400000;

  typedef logic [7:0] byte_q_t[$];

  class deframe_scoreboard;
    hltd_pkg::cfg_t             cfg;
    hltd_pkg::phase_e           ph;
    logic [7:0]                 held;
    logic [hltd_pkg::LEN_W-1:0] len_acc;
    int                         len_idx;
    logic [hltd_pkg::CNT_W-1:0] remaining;
    bit                         dead;
    hltd_pkg::result_t          expected_out[$];
    int                         errors;

    function new();
      cfg = '0;
      cfg.max_len = hltd_pkg::MAX_LEN_RESET;
      ph = hltd_pkg::PH_HEAD1;
      held = '0;
      len_acc = '0;
      len_idx = 0;
      remaining = '0;
      dead = 1'b0;
      errors = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] value);
      case (idx)
        hltd_pkg::REG_HEADER_FIRST:  cfg.header_first = value[7:0];
        hltd_pkg::REG_HEADER_SECOND: cfg.header_second = value[7:0];
        hltd_pkg::REG_TAIL_FIRST:    cfg.tail_first = value[7:0];
        hltd_pkg::REG_TAIL_SECOND:   cfg.tail_second = value[7:0];
        hltd_pkg::REG_MAX_LEN:       cfg.max_len = value[hltd_pkg::MAXLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_result(logic [7:0] b, hltd_pkg::kind_e k, hltd_pkg::cause_e c);
      hltd_pkg::result_t r;
      r.out_byte = b;
      r.out_kind = k;
      r.error_cause = c;
      expected_out.push_back(r);
    endfunction

    function void kill_session(hltd_pkg::cause_e c);
      dead = 1'b1;
      ph = hltd_pkg::PH_HEAD1;
      push_result(8'h00, hltd_pkg::KIND_ERROR, c);
    endfunction

    // one request per accepted byte
    function void note_rx_byte(logic [7:0] b);
      if (dead) return;
      case (ph)
        hltd_pkg::PH_HEAD1: begin
          held = b;
          ph = hltd_pkg::PH_HEAD2;
        end
        hltd_pkg::PH_HEAD2: begin
          if (held != cfg.header_first || b != cfg.header_second) begin
            kill_session(hltd_pkg::CAUSE_HEADER);
          end else begin
            len_acc = '0;
            len_idx = 0;
            ph = hltd_pkg::PH_LEN;
          end
        end
        hltd_pkg::PH_LEN: begin
          len_acc |= hltd_pkg::LEN_W'(b) << (8 * len_idx);
          len_idx++;
          if (len_idx >= hltd_pkg::LEN_BYTES) begin
            if (len_acc[hltd_pkg::LEN_W-1] || len_acc == 0 || len_acc > cfg.max_len ||
                len_acc > hltd_pkg::MAX_FRAME_PAYLOAD) begin
              kill_session(hltd_pkg::CAUSE_LENGTH);
            end else begin
              remaining = hltd_pkg::CNT_W'(len_acc);
              ph = hltd_pkg::PH_BODY;
            end
          end
        end
        hltd_pkg::PH_BODY: begin
          if (remaining > 0) remaining--;
          if (remaining == 0) ph = hltd_pkg::PH_TAIL1;
          push_result(b, hltd_pkg::KIND_PAYLOAD, hltd_pkg::CAUSE_NONE);
        end
        hltd_pkg::PH_TAIL1: begin
          held = b;
          ph = hltd_pkg::PH_TAIL2;
        end
        hltd_pkg::PH_TAIL2: begin
          ph = hltd_pkg::PH_HEAD1;
          push_result(8'h00, (held == cfg.tail_first && b == cfg.tail_second) ?
                      hltd_pkg::KIND_ACCEPT : hltd_pkg::KIND_DROP, hltd_pkg::CAUSE_NONE);
        end
        default: ph = hltd_pkg::PH_HEAD1;
      endcase
    endfunction

    function void check_result(logic [7:0] byte_v, logic [1:0] kind_v, logic [1:0] cause_v);
      hltd_pkg::result_t want;
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected result, actual byte %02h kind %0d cause %0d",
                 $time, byte_v, kind_v, cause_v);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      if (byte_v !== want.out_byte) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte, byte_v);
        errors++;
      end
      if (kind_v !== want.out_kind) begin
        $display("%0t: out_kind expected %0d actual %0d", $time, want.out_kind, kind_v);
        errors++;
      end
      if (cause_v !== want.error_cause) begin
        $display("%0t: error_cause expected %0d actual %0d",
                 $time, want.error_cause, cause_v);
        errors++;
      end
    endfunction
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_valid = 1'b0;
  logic [7:0]                  s_data = '0;
  logic                        m_ready = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [hltd_pkg::ADDR_W-1:0] paddr = '0;
  logic [hltd_pkg::DATA_W-1:0] pwdata = '0;
  logic [hltd_pkg::DATA_W-1:0] prdata;
  logic                        pready;
  logic                        s_axis_tready_o;
  logic                        m_axis_tvalid_o;
  logic [7:0]                  m_axis_tdata_o;
  logic [3:0]                  m_axis_tuser_o;

  deframe_scoreboard sb = new();

  int burst_left = 0;
  int bytes_sent = 0;
  bit sender_idles = 1'b1;
  int cycle_cnt = 0;

  always #6 clk_i = ~clk_i;

  header_length_tail_deframer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall pattern in randomly picked modes
  always @(posedge clk_i) begin : rx_stall
    int mode;
    if (cycle_cnt % 64 == 0) mode = $urandom_range(0, 3);
    case (mode)
      0: m_ready <= 1'b1;
      1: m_ready <= (cycle_cnt % 3 != 0);
      2: m_ready <= 1'($urandom_range(0, 1));
      default: m_ready <= cycle_cnt[3];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o[1:0], m_axis_tuser_o[3:2]);
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = sender_idles ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_valid <= 1'b1;
    s_data <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_rx_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_q_t pl, input logic [7:0] t1, input logic [7:0] t2);
    logic [hltd_pkg::LEN_W-1:0] n;
    n = hltd_pkg::LEN_W'(pl.size());
    send_byte(sb.cfg.header_first);
    send_byte(sb.cfg.header_second);
    for (int i = 0; i < hltd_pkg::LEN_BYTES; i++) send_byte(n[8*i +: 8]);
    foreach (pl[i]) send_byte(pl[i]);
    send_byte(t1);
    send_byte(t2);
  endtask

  // hold the sender until every expected result is out, plus latency slack
  task automatic drain_outputs();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_out.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_cfg(input logic [7:0] h1, input logic [7:0] h2,
                             input logic [7:0] t1, input logic [7:0] t2,
                             input logic [31:0] max_len);
    drain_outputs();
    write_reg(hltd_pkg::REG_HEADER_FIRST, h1);
    write_reg(hltd_pkg::REG_HEADER_SECOND, h2);
    write_reg(hltd_pkg::REG_TAIL_FIRST, t1);
    write_reg(hltd_pkg::REG_TAIL_SECOND, t2);
    write_reg(hltd_pkg::REG_MAX_LEN, max_len);
  endtask

  task automatic run_random_frames(input int budget);
    int stop;
    int eff;
    int len;
    int pick;
    byte_q_t pl;
    logic [7:0] t1;
    logic [7:0] t2;
    stop = bytes_sent + budget;
    sender_idles = ($urandom_range(0, 3) != 0);
    eff = (sb.cfg.max_len > hltd_pkg::MAX_FRAME_PAYLOAD) ? hltd_pkg::MAX_FRAME_PAYLOAD :
          int'(sb.cfg.max_len);
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) len = $urandom_range(1, (eff < 12) ? eff : 12);
      else if (pick < 9) len = $urandom_range(1, (eff < 200) ? eff : 200);
      else len = (eff <= 300) ? eff : $urandom_range(1, 300);
      pl.delete();
      repeat (len) pl.push_back(8'($urandom_range(0, 255)));
      t1 = sb.cfg.tail_first;
      t2 = sb.cfg.tail_second;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        t1 ^= 8'($urandom_range(1, 255));
      end else if (pick == 1) begin
        t2 ^= 8'($urandom_range(1, 255));
      end else if (pick == 2) begin
        t1 ^= 8'($urandom_range(1, 255));
        t2 ^= 8'($urandom_range(1, 255));
      end
      send_frame(pl, t1, t2);
      if ($urandom_range(0, 15) == 0) drain_outputs();
    end
  endtask

  initial begin
    byte_q_t    pl;
    int         fault;
    logic [7:0] h1;
    logic [7:0] h2;
    logic [15:0] lv;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: accepted frame, bad first tail byte, bad second tail byte
    pl = '{8'hFF};
    send_frame(pl, sb.cfg.tail_first, sb.cfg.tail_second);
    pl = '{8'h00, 8'hA5};
    send_frame(pl, ~sb.cfg.tail_first, sb.cfg.tail_second);
    pl = '{8'h5A};
    send_frame(pl, sb.cfg.tail_first, ~sb.cfg.tail_second);
    run_random_frames(180);

    program_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1);
    run_random_frames(120);

    program_cfg($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(2, 64));
    run_random_frames(200);

    // limit above the frame maximum
    program_cfg($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), 8191);
    run_random_frames(150);

    program_cfg($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), 4096);
    run_random_frames(200);

    program_cfg($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(1, 300));
    run_random_frames(200);

    // one fatal fault, then the session must stay silent
    drain_outputs();
    fault = $urandom_range(0, 6);
    h1 = sb.cfg.header_first;
    h2 = sb.cfg.header_second;
    lv = 16'($urandom_range(1, sb.cfg.max_len));
    case (fault)
      0: h1 ^= 8'($urandom_range(1, 255));
      1: h2 ^= 8'($urandom_range(1, 255));
      2: lv = '0;
      3: lv = 16'h8000 | 16'($urandom_range(0, 16'h7FFF));
      4: lv = 16'(sb.cfg.max_len + 1);
      5: begin
        write_reg(hltd_pkg::REG_MAX_LEN, 8191);
        lv = 16'($urandom_range(hltd_pkg::MAX_FRAME_PAYLOAD + 1, 16'h7FFF));
      end
      default: begin
        write_reg(hltd_pkg::REG_MAX_LEN, 0);
        lv = 16'($urandom_range(1, 100));
      end
    endcase
    send_byte(h1);
    send_byte(h2);
    send_byte(lv[7:0]);
    send_byte(lv[15:8]);
    repeat (24) send_byte(8'($urandom_range(0, 255)));

    drain_outputs();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_out.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
